### rtl/tbddc_pkg.sv
// Shared constants for the two-button debounce and double-click block.
`timescale 1ns / 1ps

package tbddc_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DEBOUNCE_TICKS     = 1'b0,
        REG_DOUBLE_CLICK_TICKS = 1'b1
    } cfg_reg_t;

    localparam cfg_word_t DEBOUNCE_TICKS_RESET     = 16'd40;
    localparam cfg_word_t DOUBLE_CLICK_TICKS_RESET = 16'd350;

endpackage

### rtl/two_button_debounce_double_click.sv
// Top level: two debounced buttons with double-click detection on button 1.
// Path: a word is taken into the input register, then its result is written into the result register.
// Throughput: one word per cycle unless a result stalls; the single pass of subtract/compare logic sets this.
// A stalled result holds the input register full; in_ready then drops until out_ready.
// Reset: asynchronous active low; buttons released, no click pending, timestamps zero,
// debounce_ticks 40 and double_click_ticks 350.
`timescale 1ns / 1ps

module two_button_debounce_double_click
    import tbddc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TIME_WIDTH-1:0]      now_ticks,
    input  logic                       button1_pressed,
    input  logic                       button2_pressed,
    input  logic                       morse_mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       ui_scroll,
    output logic                       ui_back,
    output logic                       ui_select,
    output logic                       char_gap,
    output logic                       word_gap,
    output logic                       end_message
);

    cfg_word_t debounce_ticks_reg;
    cfg_word_t double_click_ticks_reg;

    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  b1_raw_reg;
    logic                  b2_raw_reg;
    logic                  morse_reg;

    logic                  click_pending_reg;
    logic [TIME_WIDTH-1:0] release_time_reg;

    logic out_valid_reg;
    logic scroll_reg, back_reg, select_reg, cgap_reg, wgap_reg, endm_reg;

    logic                  fire;
    logic                  b1_release;
    logic                  b2_release;
    logic [TIME_WIDTH-1:0] since_release;
    logic                  in_window;
    logic                  is_double;
    logic                  timeout;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg     <= DEBOUNCE_TICKS_RESET;
            double_click_ticks_reg <= DOUBLE_CLICK_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE_TICKS:     debounce_ticks_reg     <= cfg_data;
                REG_DOUBLE_CLICK_TICKS: double_click_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg    <= now_ticks;
            b1_raw_reg <= button1_pressed;
            b2_raw_reg <= button2_pressed;
            morse_reg  <= morse_mode;
        end
    end

    tbddc_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_deb1 (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .raw            (b1_raw_reg),
        .now            (now_reg),
        .debounce_ticks (debounce_ticks_reg),
        .released       (b1_release)
    );

    tbddc_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_deb2 (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .raw            (b2_raw_reg),
        .now            (now_reg),
        .debounce_ticks (debounce_ticks_reg),
        .released       (b2_release)
    );

    // click window; a release that opens a new window cannot also time out
    assign since_release = now_reg - release_time_reg;
    assign in_window     = since_release <=
                           {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, double_click_ticks_reg};
    assign is_double     = b1_release && click_pending_reg && in_window;
    assign timeout       = !b1_release && click_pending_reg && !in_window;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_pending_reg <= 1'b0;
            release_time_reg  <= '0;
        end
        else if (fire)
        begin
            if (b1_release)
            begin
                click_pending_reg <= !is_double;
                if (!is_double)
                begin
                    release_time_reg <= now_reg;
                end
            end
            else if (timeout)
            begin
                click_pending_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            scroll_reg <= timeout && !morse_reg;
            back_reg   <= is_double;
            endm_reg   <= is_double && morse_reg;
            cgap_reg   <= b1_release && !is_double && morse_reg;
            select_reg <= b2_release && !morse_reg;
            wgap_reg   <= b2_release && morse_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ui_scroll   = scroll_reg;
    assign ui_back     = back_reg;
    assign ui_select   = select_reg;
    assign char_gap    = cgap_reg;
    assign word_gap    = wgap_reg;
    assign end_message = endm_reg;

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word produced no result");

    a_end_needs_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && endm_reg) |-> back_reg)
        else $error("end_message without ui_back");

    a_scroll_vs_b1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(scroll_reg && (back_reg || cgap_reg)))
        else $error("scroll together with a button 1 release event");

    a_b2_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(select_reg && wgap_reg))
        else $error("select and word_gap together");

    a_pending_after_double: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_double) |=> !click_pending_reg)
        else $error("click still pending after double click");

endmodule

### rtl/tbddc_debounce.sv
// Debouncer for one button: raw level tracking, edge timestamp and stable level.
`timescale 1ns / 1ps

module tbddc_debounce
    import tbddc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  raw,
    input  logic [TIME_WIDTH-1:0] now,
    input  cfg_word_t             debounce_ticks,
    output logic                  released
);

    logic                  last_raw_reg;
    logic                  stable_reg;
    logic [TIME_WIDTH-1:0] edge_time_reg;

    logic                  raw_moved;
    logic [TIME_WIDTH-1:0] held;
    logic                  change;

    // a fresh raw edge restarts the hold time at zero
    assign raw_moved = (raw != last_raw_reg);
    assign held      = raw_moved ? '0 : (now - edge_time_reg);
    assign change    = (held >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, debounce_ticks})
                       && (raw != stable_reg);
    assign released  = change && !raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            edge_time_reg <= '0;
        end
        else if (step)
        begin
            last_raw_reg <= raw;
            if (raw_moved)
            begin
                edge_time_reg <= now;
            end
            if (change)
            begin
                stable_reg <= raw;
            end
        end
    end

endmodule

### test/tb_two_button_debounce_double_click.sv
// Testbench for two_button_debounce_double_click: random press gestures checked against a predictor.
`timescale 1ns / 1ps

module tb_two_button_debounce_double_click;

    import tbddc_pkg::*;

    localparam int TW = 32;
    localparam int PHASES = 7;
    localparam int WORDS_PER_PHASE = 164;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed
    {
        logic scroll;
        logic back;
        logic select;
        logic char_gap;
        logic word_gap;
        logic end_msg;
    } ui_events_t;

    class click_scoreboard;
        cfg_word_t debounce_span;
        cfg_word_t window_span;
        bit last_raw [2];
        bit level [2];
        logic [TW-1:0] edge_at [2];
        bit pending;
        logic [TW-1:0] released_at;
        ui_events_t due_events [$];
        int mismatches;

        function new();
            debounce_span = DEBOUNCE_TICKS_RESET;
            window_span = DOUBLE_CLICK_TICKS_RESET;
            for (int b = 0; b < 2; b++)
            begin
                last_raw[b] = 1'b0;
                level[b] = 1'b0;
                edge_at[b] = '0;
            end
            pending = 1'b0;
            released_at = '0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t r, cfg_word_t v);
            if (r == REG_DEBOUNCE_TICKS)
                debounce_span = v;
            else
                window_span = v;
        endfunction

        // true when the debounced level of button b changes
        function bit settle(int b, bit raw, logic [TW-1:0] now);
            logic [TW-1:0] held;
            if (raw != last_raw[b])
                edge_at[b] = now;
            last_raw[b] = raw;
            held = now - edge_at[b];
            if (held >= debounce_span && raw != level[b])
            begin
                level[b] = raw;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_sample(logic [TW-1:0] now, bit raw1, bit raw2, bit morse);
            ui_events_t ev;
            logic [TW-1:0] since;
            ev = '0;
            if (settle(0, raw1, now) && !level[0])
            begin
                since = now - released_at;
                if (pending && since <= window_span)
                begin
                    ev.back = 1'b1;
                    ev.end_msg = morse;
                    pending = 1'b0;
                end
                else
                begin
                    pending = 1'b1;
                    released_at = now;
                    ev.char_gap = morse;
                end
            end
            since = now - released_at;
            if (pending && since > window_span)
            begin
                pending = 1'b0;
                ev.scroll = !morse;
            end
            if (settle(1, raw2, now) && !level[1])
            begin
                if (morse)
                    ev.word_gap = 1'b1;
                else
                    ev.select = 1'b1;
            end
            due_events.push_back(ev);
        endfunction

        function string describe(ui_events_t e);
            return $sformatf("scroll=%b back=%b select=%b char_gap=%b word_gap=%b end=%b",
                             e.scroll, e.back, e.select, e.char_gap, e.word_gap, e.end_msg);
        endfunction

        function void check_events(ui_events_t got);
            ui_events_t want;
            bit bad;
            if (due_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %s", describe(got));
                return;
            end
            want = due_events.pop_front();
            bad = (got.scroll !== want.scroll) || (got.back !== want.back)
                  || (got.select !== want.select) || (got.char_gap !== want.char_gap)
                  || (got.word_gap !== want.word_gap) || (got.end_msg !== want.end_msg);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %s, got %s", describe(want), describe(got));
            end
        endfunction

        function int outstanding();
            return due_events.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [TW-1:0] now_ticks = '0;
    logic button1_pressed = 1'b0;
    logic button2_pressed = 1'b0;
    logic morse_mode = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic ui_scroll;
    logic ui_back;
    logic ui_select;
    logic char_gap;
    logic word_gap;
    logic end_message;

    click_scoreboard sb;
    bit steady = 1'b0;
    int unsigned cycles = 0;
    int unsigned sent = 0;

    // stimulus state
    logic [TW-1:0] stamp = '0;
    bit lvl1 = 1'b0;
    bit lvl2 = 1'b0;
    bit morse = 1'b0;
    int unsigned dbn = 40;
    int unsigned win = 350;
    int unsigned step_max = 1;

    two_button_debounce_double_click dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .now_ticks(now_ticks),
        .button1_pressed(button1_pressed),
        .button2_pressed(button2_pressed),
        .morse_mode(morse_mode),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ui_scroll(ui_scroll),
        .ui_back(ui_back),
        .ui_select(ui_select),
        .char_gap(char_gap),
        .word_gap(word_gap),
        .end_message(end_message)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("two_button_debounce_double_click regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 18);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_events({ui_scroll, ui_back, ui_select, char_gap, word_gap, end_message});
    end

    task automatic write_reg(cfg_reg_t r, cfg_word_t v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(r, v);
        @(posedge clk);
    endtask

    task automatic send_sample(logic [TW-1:0] at, bit b1, bit b2, bit m);
        while (!steady && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ticks <= at;
        button1_pressed <= b1;
        button2_pressed <= b2;
        morse_mode <= m;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(at, b1, b2, m);
        lvl1 = b1;
        lvl2 = b2;
        sent++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // hold the given levels for span ticks, with contact bounce right after a change
    task automatic hold_levels(bit l1, bit l2, int unsigned span);
        int unsigned gone;
        int k;
        bit chg1;
        bit chg2;
        bit r1;
        bit r2;
        chg1 = l1 != lvl1;
        chg2 = l2 != lvl2;
        gone = 0;
        k = 0;
        do
        begin
            int unsigned step;
            step = $urandom_range(1, step_max);
            stamp += step;
            gone += step;
            r1 = l1 ^ (chg1 && k < 2 && $urandom_range(0, 4) == 0);
            r2 = l2 ^ (chg2 && k < 2 && $urandom_range(0, 4) == 0);
            send_sample(stamp, r1, r2, morse);
            k++;
        end
        while (gone < span);
    endtask

    task automatic play_gesture();
        int unsigned kind;
        int unsigned press_span;
        int unsigned quick_span;
        int unsigned settle_span;
        kind = $urandom_range(0, 11);
        press_span = dbn + $urandom_range(1, dbn / 2 + 4);
        quick_span = dbn + $urandom_range(1, win / 2 + 4);
        settle_span = win + dbn + $urandom_range(1, win / 4 + 4);
        if ($urandom_range(0, 5) == 0)
            morse = ~morse;
        case (kind)
            0, 1, 2:
            begin
                hold_levels(1'b1, 1'b0, press_span);
                hold_levels(1'b0, 1'b0, quick_span);
                if ($urandom_range(0, 3) == 0)
                    morse = ~morse;
                hold_levels(1'b0, 1'b0, settle_span);
            end
            3, 4, 5:
            begin
                hold_levels(1'b1, 1'b0, press_span);
                hold_levels(1'b0, 1'b0, quick_span);
                hold_levels(1'b1, 1'b0, press_span);
                hold_levels(1'b0, 1'b0, settle_span);
            end
            6, 7:
            begin
                hold_levels(1'b0, 1'b1, press_span);
                hold_levels(1'b0, 1'b0, press_span);
            end
            8:
            begin
                hold_levels(1'b1, 1'b1, press_span);
                hold_levels(1'b0, 1'b0, settle_span);
            end
            9:
            begin
                hold_levels(1'b1, 1'b0, press_span);
                hold_levels(1'b1, 1'b1, press_span);
                hold_levels(1'b0, 1'b1, press_span);
                hold_levels(1'b0, 1'b0, settle_span);
            end
            10:
            begin
                repeat (4)
                begin
                    case ($urandom_range(0, 3))
                        0: stamp = $urandom();
                        1: stamp = stamp - $urandom_range(0, step_max);
                        default: stamp = stamp + $urandom_range(0, step_max);
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        morse = ~morse;
                    send_sample(stamp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                morse);
                end
            end
            default:
            begin
                repeat (3)
                begin
                    hold_levels(1'b1, 1'b0, press_span);
                    hold_levels(1'b0, 1'b0, quick_span);
                end
                hold_levels(1'b0, 1'b0, settle_span);
            end
        endcase
    endtask

    int unsigned dbn_list [PHASES] = '{40, 0, 65535, 3, 0, 65535, 0};
    int unsigned win_list [PHASES] = '{350, 0, 65535, 25, 65535, 0, 0};

    initial
    begin
        int unsigned phase_end;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: press, release, double click, lone click timeout, morse events
        send_sample(32'd0, 1'b0, 1'b0, 1'b0);
        send_sample(32'd10, 1'b1, 1'b1, 1'b0);
        send_sample(32'd50, 1'b1, 1'b1, 1'b0);
        send_sample(32'd60, 1'b0, 1'b0, 1'b0);
        send_sample(32'd100, 1'b0, 1'b0, 1'b0);
        send_sample(32'd110, 1'b1, 1'b0, 1'b0);
        send_sample(32'd150, 1'b1, 1'b0, 1'b0);
        send_sample(32'd160, 1'b0, 1'b1, 1'b1);
        send_sample(32'd200, 1'b0, 1'b1, 1'b1);
        send_sample(32'd210, 1'b1, 1'b0, 1'b1);
        send_sample(32'd250, 1'b1, 1'b0, 1'b1);
        send_sample(32'd260, 1'b0, 1'b0, 1'b1);
        send_sample(32'd300, 1'b0, 1'b0, 1'b1);
        // morse timeout clears the click silently
        send_sample(32'd651, 1'b0, 1'b0, 1'b1);
        send_sample(32'd660, 1'b1, 1'b0, 1'b0);
        send_sample(32'd700, 1'b1, 1'b0, 1'b0);
        send_sample(32'd710, 1'b0, 1'b0, 1'b0);
        send_sample(32'd750, 1'b0, 1'b0, 1'b0);
        send_sample(32'd800, 1'b1, 1'b0, 1'b0);
        send_sample(32'd810, 1'b0, 1'b0, 1'b0);
        // window runs out with no settled release in it (the short press does not settle): scroll
        send_sample(32'd1150, 1'b0, 1'b0, 1'b0);
        send_sample(32'd1501, 1'b0, 1'b0, 1'b0);
        // timestamp wrap
        send_sample(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0);
        send_sample(32'h0000_0018, 1'b1, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        stamp = 32'hFFFF_FFFF;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_quiet();
            dbn = dbn_list[p];
            win = win_list[p];
            if (p == PHASES - 1)
            begin
                dbn = $urandom_range(1, 60);
                win = $urandom_range(dbn, 500);
            end
            if (p != 0)
            begin
                write_reg(REG_DEBOUNCE_TICKS, cfg_word_t'(dbn));
                write_reg(REG_DOUBLE_CLICK_TICKS, cfg_word_t'(win));
            end
            step_max = dbn / 3 + win / 8 + 1;
            steady = (p == 3);
            if ($urandom_range(0, 1) == 1)
                stamp = $urandom();
            phase_end = sent + WORDS_PER_PHASE;
            while (sent < phase_end)
                play_gesture();
        end
        steady = 1'b0;
        wait_quiet();
        repeat (4) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("two_button_debounce_double_click regression: pass");
        else
            $display("two_button_debounce_double_click regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/tbddc_pkg.sv
rtl/tbddc_debounce.sv
rtl/two_button_debounce_double_click.sv
test/tb_two_button_debounce_double_click.sv
